>>> hw/rtl/csr_sparse_matrix_vector_engine_defines.svh
// Assertion macros shared by the sparse matrix engine RTL.
`ifndef CSR_SPARSE_MATRIX_VECTOR_ENGINE_DEFINES_SVH
`define CSR_SPARSE_MATRIX_VECTOR_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("implication check failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, ck, rn, pre, post)
`define ASSERT_NEXT(label, ck, rn, pre, post)
`endif
`endif

>>> hw/rtl/csrsmv_pkg.sv
// Shared constants, operation codes and interface types of the sparse matrix engine.
package csrsmv_pkg;

    // Store sizes.
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int MAX_ENTRIES = 1024;

    // Field widths.
    localparam int OP_W  = 3;
    localparam int ROW_W = 7;
    localparam int COL_W = 6;
    localparam int POS_W = 11;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    // Derived address and counter widths.
    localparam int ROWPTR_AW = $clog2(MAX_ROWS + 1);
    localparam int ENTRY_AW  = $clog2(MAX_ENTRIES);
    localparam int PTR_W     = $clog2(MAX_ENTRIES + 1);
    localparam int VEC_AW    = $clog2(MAX_COLS);
    localparam int ACC_W     = VAL_W + $clog2(MAX_ENTRIES) + 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WR_VEC   = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_ROW   = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_ENTRY = 3'd2;
    localparam logic [OP_W-1:0] OP_PRODUCT  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ     = 3'd4;
    localparam logic [OP_W-1:0] OP_SCALE    = 3'd5;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic clear_run;
        logic do_write;
        logic ptr_read;
        logic walk_load_ptrs;
        logic walk_load_all;
        logic walk_step;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            range_err;
        logic            walk_done;
        logic            pipe_busy;
    } dp_stat_t;

endpackage

>>> hw/rtl/csrsmv_dp.sv
// Datapath: item registers, matrix and vector stores, entry walk pipeline, result register.
module csrsmv_dp
    import csrsmv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [OP_W-1:0]         operation,
    input  logic [ROW_W-1:0]        row,
    input  logic [COL_W-1:0]        column,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    output logic signed [VAL_W-1:0] result_value,
    output logic [ST_W-1:0]         status
);

    localparam logic signed [63:0] Q_HALF  = 64'sh8000;
    localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Item registers.
    logic [OP_W-1:0]         op_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        col_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] val_reg;

    // Stores.
    logic [POS_W-1:0]        row_starts    [MAX_ROWS + 1];
    logic [COL_W-1:0]        entry_columns [MAX_ENTRIES];
    logic signed [VAL_W-1:0] entry_values  [MAX_ENTRIES];
    logic signed [VAL_W-1:0] vector_store  [MAX_COLS];

    // Row pointers and walk counter.
    logic [POS_W-1:0] ptr_lo_reg;
    logic [POS_W-1:0] ptr_hi_reg;
    logic [PTR_W-1:0] walk_k_reg;
    logic [PTR_W-1:0] walk_end_reg;
    logic [ENTRY_AW-1:0] walk_idx;

    // Pipeline stages.
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [COL_W-1:0]        s1_col_reg, s2_col_reg;
    logic signed [VAL_W-1:0] s1_val_reg, s2_val_reg, s3_val_reg, s4_val_reg;
    logic [ENTRY_AW-1:0]     s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic signed [VAL_W-1:0] s2_vec_reg;
    logic                    s2_col_ok_reg;
    logic signed [VAL_W-1:0] s2_mult;
    logic signed [63:0]      s3_prod_reg;
    logic                    s3_match_reg, s4_match_reg;
    logic signed [VAL_W-1:0] s4_term_reg;
    logic                    s4_sat_reg;

    // Rounding and saturation of a product.
    logic signed [63:0] prod_rnd;
    logic signed [47:0] prod_shd;
    logic               prod_fits;
    logic signed [VAL_W-1:0] prod_term;

    // Run accumulators.
    logic signed [ACC_W-1:0] acc_reg;
    logic                    sat_reg;
    logic                    found_reg;
    logic signed [VAL_W-1:0] found_val_reg;
    logic                    acc_fits;
    logic signed [VAL_W-1:0] acc_sat;

    // Result.
    logic range_err;
    logic signed [VAL_W-1:0] result_next;
    logic [ST_W-1:0]         status_next;
    logic signed [VAL_W-1:0] result_value_reg;
    logic [ST_W-1:0]         status_reg;

    logic is_scale;
    logic is_product;
    logic is_read;

    assign is_scale   = (op_reg == OP_SCALE);
    assign is_product = (op_reg == OP_PRODUCT);
    assign is_read    = (op_reg == OP_READ);

    // Capture the item on its input transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= operation;
            row_reg <= row;
            col_reg <= column;
            pos_reg <= position;
            val_reg <= value;
        end
    end

    // Index range check per operation.
    always_comb
    begin
        case (op_reg)
            OP_WR_VEC:   range_err = (32'(col_reg) >= MAX_COLS);
            OP_WR_ROW:   range_err = (32'(row_reg) > MAX_ROWS) || (32'(pos_reg) > MAX_ENTRIES);
            OP_WR_ENTRY: range_err = (32'(pos_reg) >= MAX_ENTRIES) ||
                                     (32'(col_reg) >= MAX_COLS);
            OP_PRODUCT:  range_err = (32'(row_reg) >= MAX_ROWS);
            OP_READ:     range_err = (32'(row_reg) >= MAX_ROWS) || (32'(col_reg) >= MAX_COLS);
            OP_SCALE:    range_err = 1'b0;
            default:     range_err = 1'b1;
        endcase
    end

    // Vector store: written by vector loads, read by stage two.
    always_ff @(posedge clk)
    begin
        if (cmd.do_write && (op_reg == OP_WR_VEC))
        begin
            vector_store[VEC_AW'(col_reg)] <= val_reg;
        end
        if (s1_valid_reg)
        begin
            s2_vec_reg <= vector_store[VEC_AW'(s1_col_reg)];
        end
    end

    // Row pointer store: one write port, two read ports for start and end.
    always_ff @(posedge clk)
    begin
        if (cmd.do_write && (op_reg == OP_WR_ROW))
        begin
            row_starts[ROWPTR_AW'(row_reg)] <= pos_reg;
        end
        if (cmd.ptr_read)
        begin
            ptr_lo_reg <= row_starts[ROWPTR_AW'(row_reg)];
            ptr_hi_reg <= row_starts[ROWPTR_AW'(row_reg) + ROWPTR_AW'(1)];
        end
    end

    // Entry column store.
    always_ff @(posedge clk)
    begin
        if (cmd.do_write && (op_reg == OP_WR_ENTRY))
        begin
            entry_columns[ENTRY_AW'(pos_reg)] <= col_reg;
        end
        if (cmd.walk_step)
        begin
            s1_col_reg <= entry_columns[walk_idx];
        end
    end

    // Entry value store: loads, and write-back of scaled values.
    always_ff @(posedge clk)
    begin
        if (cmd.do_write && (op_reg == OP_WR_ENTRY))
        begin
            entry_values[ENTRY_AW'(pos_reg)] <= val_reg;
        end
        else if (s4_valid_reg && is_scale)
        begin
            entry_values[s4_idx_reg] <= s4_term_reg;
        end
        if (cmd.walk_step)
        begin
            s1_val_reg <= entry_values[walk_idx];
        end
    end

    // Walk counter over the entry slots.
    assign walk_idx = walk_k_reg[ENTRY_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_k_reg   <= '0;
            walk_end_reg <= '0;
        end
        else if (cmd.walk_load_ptrs)
        begin
            walk_k_reg   <= PTR_W'(ptr_lo_reg);
            walk_end_reg <= (32'(ptr_hi_reg) > MAX_ENTRIES) ? PTR_W'(MAX_ENTRIES)
                                                             : PTR_W'(ptr_hi_reg);
        end
        else if (cmd.walk_load_all)
        begin
            walk_k_reg   <= '0;
            walk_end_reg <= PTR_W'(MAX_ENTRIES);
        end
        else if (cmd.walk_step)
        begin
            walk_k_reg <= walk_k_reg + PTR_W'(1);
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.walk_step;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_step)
        begin
            s1_idx_reg <= walk_idx;
        end
    end

    // Stage two: carry the entry along with the vector element read.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_col_reg    <= s1_col_reg;
            s2_val_reg    <= s1_val_reg;
            s2_idx_reg    <= s1_idx_reg;
            s2_col_ok_reg <= (32'(s1_col_reg) < MAX_COLS);
        end
    end

    // Stage three: full-precision product and column match.
    assign s2_mult = is_scale ? val_reg : (s2_col_ok_reg ? s2_vec_reg : '0);

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_prod_reg  <= 64'(s2_val_reg) * 64'(s2_mult);
            s3_match_reg <= (s2_col_reg == col_reg);
            s3_val_reg   <= s2_val_reg;
            s3_idx_reg   <= s2_idx_reg;
        end
    end

    // Stage four: round half up, drop 16 fraction bits, saturate to 32 bits.
    assign prod_rnd  = s3_prod_reg + Q_HALF;
    assign prod_shd  = $signed(prod_rnd[63:16]);
    assign prod_fits = (&prod_shd[47:VAL_W-1]) || !(|prod_shd[47:VAL_W-1]);
    assign prod_term = prod_fits ? prod_shd[VAL_W-1:0] : (prod_shd[47] ? SAT_MIN : SAT_MAX);

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            s4_term_reg  <= prod_term;
            s4_sat_reg   <= !prod_fits;
            s4_match_reg <= s3_match_reg;
            s4_val_reg   <= s3_val_reg;
            s4_idx_reg   <= s3_idx_reg;
        end
    end

    // Stage five: accumulate, flag saturation, keep the first column match.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            found_reg     <= 1'b0;
            found_val_reg <= '0;
        end
        else if (cmd.clear_run)
        begin
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (s4_valid_reg)
        begin
            if (is_product)
            begin
                acc_reg <= acc_reg + ACC_W'(s4_term_reg);
            end
            if (is_product || is_scale)
            begin
                sat_reg <= sat_reg || s4_sat_reg;
            end
            if (is_read && s4_match_reg && !found_reg)
            begin
                found_reg     <= 1'b1;
                found_val_reg <= s4_val_reg;
            end
        end
    end

    // Final saturation of the row sum.
    assign acc_fits = (&acc_reg[ACC_W-1:VAL_W-1]) || !(|acc_reg[ACC_W-1:VAL_W-1]);
    assign acc_sat  = acc_fits ? acc_reg[VAL_W-1:0] : (acc_reg[ACC_W-1] ? SAT_MIN : SAT_MAX);

    // Result selection.
    always_comb
    begin
        result_next = '0;
        status_next = ST_OK;
        if (range_err)
        begin
            status_next = ST_RANGE;
        end
        else
        begin
            case (op_reg)
                OP_PRODUCT:
                begin
                    result_next = acc_sat;
                    status_next = (sat_reg || !acc_fits) ? ST_SAT : ST_OK;
                end
                OP_READ:
                begin
                    result_next = found_reg ? found_val_reg : '0;
                end
                OP_SCALE:
                begin
                    status_next = sat_reg ? ST_SAT : ST_OK;
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_value_reg <= result_next;
            status_reg       <= status_next;
        end
    end

    assign result_value = result_value_reg;
    assign status       = status_reg;

    assign stat.op        = op_reg;
    assign stat.range_err = range_err;
    assign stat.walk_done = (walk_k_reg >= walk_end_reg);
    assign stat.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

endmodule

>>> hw/rtl/csrsmv_ctrl.sv
// Controller: sequences each operation and owns the input and output handshakes.
module csrsmv_ctrl
    import csrsmv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_PTR    = 6'b000100,
        S_WALK   = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    // Next state and datapath commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.clear_run = 1'b1;
                if (stat.range_err)
                begin
                    state_next = S_RESP;
                end
                else if (stat.op inside {OP_WR_VEC, OP_WR_ROW, OP_WR_ENTRY})
                begin
                    cmd.do_write = 1'b1;
                    state_next   = S_RESP;
                end
                else if (stat.op inside {OP_PRODUCT, OP_READ})
                begin
                    cmd.ptr_read = 1'b1;
                    state_next   = S_PTR;
                end
                else if (stat.op == OP_SCALE)
                begin
                    cmd.walk_load_all = 1'b1;
                    state_next        = S_WALK;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_PTR:
            begin
                cmd.walk_load_ptrs = 1'b1;
                state_next         = S_WALK;
            end
            S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/csr_sparse_matrix_vector_engine.sv
// Sparse matrix engine in compressed-row form with a dense vector (top level).
//
// Input channel (in_valid/in_ready) carries one operation per transfer: vector
// write, row start write, entry write, row product, element read or scale.
// Output channel (out_valid/out_ready) returns exactly one result per operation.
// Writes and rejected operations go from decode straight to the response;
// a row product or element read first reads the row pointers, then walks the
// row's stored entries and drains the pipeline; a scale walks all MAX_ENTRIES
// entry slots and drains the pipeline before it responds.
// One item is worked on at a time; the entry walk issues one entry per cycle
// through the single read port of the entry stores, so throughput follows the
// row length.
// A finished result sits in the output register; the next item is accepted
// while it waits, and the block stalls before delivering that next result
// until the receiver takes the pending one.
// Reset clears the controller, pipeline flags, walk counter and accumulators;
// the stores hold no defined contents until written; there is no clearing pass.
`include "csr_sparse_matrix_vector_engine_defines.svh"
module csr_sparse_matrix_vector_engine
    import csrsmv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [OP_W-1:0]         operation,
    input  logic [ROW_W-1:0]        row,
    input  logic [COL_W-1:0]        column,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] result_value,
    output logic [ST_W-1:0]         status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller.
    csrsmv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath.
    csrsmv_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (operation),
        .row          (row),
        .column       (column),
        .position     (position),
        .value        (value),
        .cmd          (cmd),
        .stat         (stat),
        .result_value (result_value),
        .status       (status)
    );

    // The walk never issues an entry past the end of its range.
    `ASSERT_IMPLY(a_walk_in_range, clk, rst_n, cmd.walk_step, !stat.walk_done)
    // A result is never loaded while entries are still in flight.
    `ASSERT_IMPLY(a_load_after_drain, clk, rst_n, cmd.out_load, !stat.pipe_busy)
    // No new item is taken while the pipeline still works on one.
    `ASSERT_IMPLY(a_busy_blocks_input, clk, rst_n, stat.pipe_busy, !in_ready)
    // In the cycle after an input transfer the block does not accept another item.
    `ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
